// ----- rtl/core/bbw_pkg.sv -----
package bbw_pkg;

  localparam int NUM_BUSES_DEF = 256;
  localparam int BUS_W = 8;
  localparam int DEVFN_W = 8;

  localparam logic ACT_RECORD = 1'b0;
  localparam logic ACT_LOOKUP = 1'b1;

  localparam logic [1:0] ST_NONE  = 2'd0;
  localparam logic [1:0] ST_FOUND = 2'd1;
  localparam logic [1:0] ST_LIMIT = 2'd2;

  typedef struct packed {
    logic               action;
    logic [BUS_W-1:0]   bus;
    logic [DEVFN_W-1:0] devfn;
    logic [BUS_W-1:0]   first_bus;
    logic [BUS_W-1:0]   last_bus;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [BUS_W-1:0]   top_bus;
    logic [DEVFN_W-1:0] top_devfn;
    logic [BUS_W-1:0]   secondary_bus;
  } out_item_t;

  typedef struct packed {
    logic [BUS_W-1:0]   parent_bus;
    logic [DEVFN_W-1:0] parent_devfn;
  } tbl_entry_t;

  typedef struct packed {
    logic             we;
    logic [BUS_W-1:0] waddr;
    tbl_entry_t       wdata;
    logic             re;
    logic [BUS_W-1:0] raddr;
  } tbl_req_t;

  typedef struct packed {
    logic       rvalid;
    tbl_entry_t rdata;
  } tbl_rsp_t;

endpackage

// ----- rtl/core/bbw_table.sv -----
module bbw_table #(
  parameter int NUM_BUSES = bbw_pkg::NUM_BUSES_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  bbw_pkg::tbl_req_t req,
  output bbw_pkg::tbl_rsp_t rsp
);

  localparam int AW = $clog2(NUM_BUSES);

  // valid bits live in flops so a reset clears the whole map
  logic [NUM_BUSES-1:0] valid_r;
  bbw_pkg::tbl_entry_t  mem [NUM_BUSES];
  logic                 rvalid_r;
  bbw_pkg::tbl_entry_t  rdata_r;

  logic          wr_hit;
  logic          rd_hit;
  logic [AW-1:0] widx;
  logic [AW-1:0] ridx;

  assign wr_hit = req.we && (32'(req.waddr) < NUM_BUSES);
  assign rd_hit = req.re && (32'(req.raddr) < NUM_BUSES);
  assign widx   = req.waddr[AW-1:0];
  assign ridx   = req.raddr[AW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= '0;
      rvalid_r <= 1'b0;
    end else begin
      if (wr_hit) begin
        valid_r[widx] <= 1'b1;
      end
      rvalid_r <= rd_hit && valid_r[ridx];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_hit) begin
      mem[widx] <= req.wdata;
    end
    if (rd_hit) begin
      rdata_r <= mem[ridx];
    end
  end

  assign rsp.rvalid = rvalid_r;
  assign rsp.rdata  = rdata_r;

endmodule

// ----- rtl/core/bbw_walker.sv -----
module bbw_walker #(
  parameter int NUM_BUSES = bbw_pkg::NUM_BUSES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  bbw_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output bbw_pkg::out_item_t out_data,
  output bbw_pkg::tbl_req_t  tbl_req,
  input  bbw_pkg::tbl_rsp_t  tbl_rsp
);

  localparam int SW = $clog2(NUM_BUSES + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_FILL,
    S_WALK,
    S_DONE
  } state_t;

  state_t                        state_r, state_nxt;
  logic [1:0]                    status_r, status_nxt;
  logic [bbw_pkg::BUS_W-1:0]     cur_r, cur_nxt;
  logic [bbw_pkg::DEVFN_W-1:0]   dfn_r, dfn_nxt;
  logic [bbw_pkg::BUS_W-1:0]     sec_r, sec_nxt;
  logic [bbw_pkg::BUS_W-1:0]     fill_r, fill_nxt;
  logic [bbw_pkg::BUS_W-1:0]     last_r, last_nxt;
  logic [SW-1:0]                 steps_r, steps_nxt;
  logic                          first_r, first_nxt;
  logic                          out_valid_r, out_valid_nxt;
  bbw_pkg::out_item_t            out_data_r, out_data_nxt;

  logic accept;

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;

  always_comb begin
    state_nxt     = state_r;
    status_nxt    = status_r;
    cur_nxt       = cur_r;
    dfn_nxt       = dfn_r;
    sec_nxt       = sec_r;
    fill_nxt      = fill_r;
    last_nxt      = last_r;
    steps_nxt     = steps_r;
    first_nxt     = first_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    tbl_req       = '0;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          status_nxt = bbw_pkg::ST_NONE;
          cur_nxt    = in_data.bus;
          dfn_nxt    = in_data.devfn;
          sec_nxt    = '0;
          fill_nxt   = in_data.first_bus;
          last_nxt   = in_data.last_bus;
          steps_nxt  = '0;
          first_nxt  = 1'b1;
          if (in_data.action == bbw_pkg::ACT_RECORD) begin
            state_nxt = (in_data.first_bus <= in_data.last_bus) ? S_FILL : S_DONE;
          end else if (in_data.bus != '0) begin
            tbl_req.re    = 1'b1;
            tbl_req.raddr = in_data.bus;
            state_nxt     = S_WALK;
          end else begin
            state_nxt = S_DONE;
          end
        end
      end
      S_FILL: begin
        // cur/dfn hold the bridge being recorded
        tbl_req.we                 = 1'b1;
        tbl_req.waddr              = fill_r;
        tbl_req.wdata.parent_bus   = cur_r;
        tbl_req.wdata.parent_devfn = dfn_r;
        if (fill_r == last_r) begin
          state_nxt = S_DONE;
        end else begin
          fill_nxt = fill_r + 1'b1;
        end
      end
      S_WALK: begin
        if (!tbl_rsp.rvalid) begin
          status_nxt = first_r ? bbw_pkg::ST_NONE : bbw_pkg::ST_FOUND;
          state_nxt  = S_DONE;
        end else begin
          sec_nxt   = cur_r;
          cur_nxt   = tbl_rsp.rdata.parent_bus;
          dfn_nxt   = tbl_rsp.rdata.parent_devfn;
          first_nxt = 1'b0;
          if (steps_r == SW'(NUM_BUSES)) begin
            status_nxt = bbw_pkg::ST_LIMIT;
            state_nxt  = S_DONE;
          end else begin
            // next link read goes straight off the returned parent bus
            steps_nxt     = steps_r + 1'b1;
            tbl_req.re    = 1'b1;
            tbl_req.raddr = tbl_rsp.rdata.parent_bus;
          end
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt              = 1'b1;
          out_data_nxt.status        = status_r;
          out_data_nxt.top_bus       = cur_r;
          out_data_nxt.top_devfn     = dfn_r;
          out_data_nxt.secondary_bus = sec_r;
          state_nxt                  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      first_r     <= 1'b0;
      steps_r     <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      first_r     <= first_nxt;
      steps_r     <= steps_nxt;
    end
    status_r   <= status_nxt;
    cur_r      <= cur_nxt;
    dfn_r      <= dfn_nxt;
    sec_r      <= sec_nxt;
    fill_r     <= fill_nxt;
    last_r     <= last_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ----- rtl/core/bus_to_bridge_map_walker_unit.sv -----
// Record: the item is accepted, S_FILL writes each bus in [first_bus, last_bus] in turn
//   (an empty range skips S_FILL), then S_DONE loads the result register.
// Lookup: the item is accepted, S_WALK issues one table read per parent link, then
//   S_DONE loads the result register; the walk is bound by the single table read port.
// One item in flight; the next item is accepted while the last result waits.
// Synchronous active-low reset clears all map valid bits.
module bus_to_bridge_map_walker_unit #(
  parameter int NUM_BUSES = bbw_pkg::NUM_BUSES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  bbw_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output bbw_pkg::out_item_t out_data
);

  bbw_pkg::tbl_req_t tbl_req;
  bbw_pkg::tbl_rsp_t tbl_rsp;

  bbw_walker #(
    .NUM_BUSES(NUM_BUSES)
  ) u_walker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .tbl_req   (tbl_req),
    .tbl_rsp   (tbl_rsp)
  );

  bbw_table #(
    .NUM_BUSES(NUM_BUSES)
  ) u_table (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (tbl_req),
    .rsp   (tbl_rsp)
  );

endmodule

// ----- rtl/core/bbw_checker.sv -----
module bbw_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input bbw_pkg::in_item_t  in_data,
  input logic               out_valid,
  input logic               out_ready,
  input bbw_pkg::out_item_t out_data
);

  // one item at a time: busy right after an accepted beat
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted again right after a beat");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result beat changed");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.status <= bbw_pkg::ST_LIMIT)
    else $error("undefined status code");

  a_none_sec_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == bbw_pkg::ST_NONE |-> out_data.secondary_bus == '0)
    else $error("secondary bus set without a bridge");

endmodule

bind bus_to_bridge_map_walker_unit bbw_checker u_bbw_checker (.*);

// ----- tb/bbw_walk_checker.sv -----
module bbw_walk_checker #(
  parameter int NUM_BUSES = bbw_pkg::NUM_BUSES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  bbw_pkg::in_item_t  in_data,
  input  logic               out_valid,
  input  logic               out_ready,
  input  bbw_pkg::out_item_t out_data,
  output int                 mismatches,
  output int                 outstanding,
  output int                 records,
  output int                 lookups,
  output int                 found,
  output int                 limited
);

  typedef struct packed {
    logic                        mapped;
    logic [bbw_pkg::BUS_W-1:0]   up_bus;
    logic [bbw_pkg::DEVFN_W-1:0] up_devfn;
  } bridge_link_t;

  bridge_link_t       bridge_links [NUM_BUSES];
  bbw_pkg::out_item_t pending_answers [$];

  function automatic logic bus_mapped(input int b);
    return (b < NUM_BUSES) && bridge_links[b].mapped;
  endfunction

  // Applies one beat to the bridge map and returns the answer it must produce.
  function automatic bbw_pkg::out_item_t walk_bridges(input bbw_pkg::in_item_t it);
    bbw_pkg::out_item_t          ans;
    int                          b;
    int                          cur;
    int                          steps;
    logic                        gave_up;
    logic [bbw_pkg::DEVFN_W-1:0] dfn;
    ans.status        = bbw_pkg::ST_NONE;
    ans.top_bus       = it.bus;
    ans.top_devfn     = it.devfn;
    ans.secondary_bus = '0;
    if (it.action == bbw_pkg::ACT_RECORD) begin
      // fill ends at bus 255, no wrap
      for (b = int'(it.first_bus); b <= int'(it.last_bus); b++) begin
        if (b < NUM_BUSES) begin
          bridge_links[b] = '{1'b1, it.bus, it.devfn};
        end
      end
    end else if (it.bus != '0 && bus_mapped(int'(it.bus))) begin
      cur     = int'(it.bus);
      dfn     = it.devfn;
      steps   = 0;
      gave_up = 1'b0;
      ans.status = bbw_pkg::ST_FOUND;
      while (!gave_up && bus_mapped(cur)) begin
        ans.secondary_bus = bbw_pkg::BUS_W'(cur);
        dfn = bridge_links[cur].up_devfn;
        cur = int'(bridge_links[cur].up_bus);
        if (steps >= NUM_BUSES) begin
          ans.status = bbw_pkg::ST_LIMIT;
          gave_up    = 1'b1;
        end else begin
          steps++;
        end
      end
      ans.top_bus   = bbw_pkg::BUS_W'(cur);
      ans.top_devfn = dfn;
    end
    return ans;
  endfunction

  task automatic check_field(input string field, input logic [7:0] want,
                             input logic [7:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s mismatch: expected 0x%02h, got 0x%02h", $time, field, want, got);
    end
  endtask

  always @(posedge clk) begin
    bbw_pkg::out_item_t want;
    if (!rst_n) begin
      foreach (bridge_links[b]) bridge_links[b] = '0;
      pending_answers.delete();
    end else begin
      if (in_valid && in_ready) begin
        want = walk_bridges(in_data);
        pending_answers.push_back(want);
        if (in_data.action == bbw_pkg::ACT_RECORD) records++;
        else lookups++;
        if (want.status == bbw_pkg::ST_FOUND) found++;
        if (want.status == bbw_pkg::ST_LIMIT) limited++;
      end
      if (out_valid && out_ready) begin
        if (pending_answers.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result beat: expected none, got %h", $time, out_data);
        end else begin
          want = pending_answers.pop_front();
          check_field("status", {6'd0, want.status}, {6'd0, out_data.status});
          check_field("top_bus", want.top_bus, out_data.top_bus);
          check_field("top_devfn", want.top_devfn, out_data.top_devfn);
          check_field("secondary_bus", want.secondary_bus, out_data.secondary_bus);
        end
      end
    end
    outstanding <= pending_answers.size();
  end

endmodule

// ----- tb/bus_to_bridge_map_walker_unit_tb.sv -----
module bus_to_bridge_map_walker_unit_tb;

  localparam int RANDOM_BEATS = 850;

  typedef enum int {RX_OPEN, RX_BUSY, RX_SLOW} rx_mode_t;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  bbw_pkg::in_item_t  in_data;
  logic               out_valid;
  logic               out_ready;
  bbw_pkg::out_item_t out_data;

  int mismatches, outstanding, records, lookups, found, limited;

  bbw_pkg::in_item_t beats [$];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  bus_to_bridge_map_walker_unit u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  bbw_walk_checker u_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .mismatches  (mismatches),
    .outstanding (outstanding),
    .records     (records),
    .lookups     (lookups),
    .found       (found),
    .limited     (limited)
  );

  function automatic bbw_pkg::in_item_t record_beat(input logic [7:0] bus,
                                                    input logic [7:0] devfn,
                                                    input logic [7:0] first,
                                                    input logic [7:0] last);
    bbw_pkg::in_item_t it;
    it.action    = bbw_pkg::ACT_RECORD;
    it.bus       = bus;
    it.devfn     = devfn;
    it.first_bus = first;
    it.last_bus  = last;
    return it;
  endfunction

  // range fields are don't-care on a lookup, so fill them with junk
  function automatic bbw_pkg::in_item_t lookup_beat(input logic [7:0] bus,
                                                    input logic [7:0] devfn);
    bbw_pkg::in_item_t it;
    it.action    = bbw_pkg::ACT_LOOKUP;
    it.bus       = bus;
    it.devfn     = devfn;
    it.first_bus = 8'($urandom);
    it.last_bus  = 8'($urandom);
    return it;
  endfunction

  task automatic plan_directed();
    beats.push_back(lookup_beat(8'h00, 8'h42));
    beats.push_back(lookup_beat(8'hc8, 8'hff));
    beats.push_back(record_beat(8'h00, 8'h08, 8'h01, 8'h20));
    beats.push_back(record_beat(8'h01, 8'h10, 8'h02, 8'h05));
    beats.push_back(record_beat(8'h02, 8'hff, 8'h03, 8'h03));
    beats.push_back(lookup_beat(8'h03, 8'h55));
    beats.push_back(record_beat(8'h09, 8'h77, 8'h30, 8'h2f));  // first > last: no-op
    beats.push_back(lookup_beat(8'h30, 8'h00));
    beats.push_back(record_beat(8'h40, 8'haa, 8'hf0, 8'hff));  // runs to the top bus
    beats.push_back(lookup_beat(8'hff, 8'h01));
    beats.push_back(record_beat(8'hff, 8'h00, 8'hfe, 8'hfe));
    beats.push_back(lookup_beat(8'hfe, 8'h12));
    beats.push_back(record_beat(8'h80, 8'h01, 8'h00, 8'h00));  // map bus 0 itself
    beats.push_back(lookup_beat(8'h00, 8'h33));                 // still no bridge
    beats.push_back(lookup_beat(8'h03, 8'h44));                 // walk passes through bus 0
    beats.push_back(record_beat(8'h60, 8'hc3, 8'h60, 8'h60));  // bus is its own parent
    beats.push_back(lookup_beat(8'h60, 8'h99));
    beats.push_back(record_beat(8'h71, 8'h5a, 8'h70, 8'h70));
    beats.push_back(record_beat(8'h70, 8'ha5, 8'h71, 8'h71));
    beats.push_back(lookup_beat(8'h71, 8'hee));
    beats.push_back(record_beat(8'hff, 8'hff, 8'hff, 8'hff));
    beats.push_back(lookup_beat(8'hfe, 8'h00));
    beats.push_back(lookup_beat(8'h20, 8'h80));
  endtask

  // Mostly well-formed trees: each 32-bus segment keeps its base bus unmapped as a
  // root, and every bridge sits on a lower bus of the same segment, so walks end
  // at a root. A few stray records add loops and cross links.
  task automatic plan_random(input int count);
    int                i, roll, seg_base, first, width, last, span, parent;
    logic [7:0]        start;
    logic [7:0]        recent [$];
    bbw_pkg::in_item_t it;
    for (i = 0; i < count; i++) begin
      roll = $urandom_range(0, 99);
      if (i == count - 15) begin
        it = record_beat(8'($urandom), 8'($urandom), 8'h00, 8'hff);
      end else if (roll < 40) begin
        seg_base = $urandom_range(0, 7) * 32;
        first    = seg_base + $urandom_range(1, 31);
        width    = ($urandom_range(0, 9) == 0) ? $urandom_range(4, 12) : $urandom_range(0, 3);
        last     = (first + width > seg_base + 31) ? seg_base + 31 : first + width;
        span     = (first - seg_base > 4) ? 4 : first - seg_base;
        parent   = first - $urandom_range(1, span);
        it = record_beat(8'(parent), 8'($urandom), 8'(first), 8'(last));
        recent.push_back(8'(first));
        if (recent.size() > 24) void'(recent.pop_front());
      end else if (roll < 45) begin
        first = $urandom_range(0, 255);
        last  = first + $urandom_range(0, 3);
        if (last > 255) last = 255;
        it = record_beat(8'($urandom), 8'($urandom), 8'(first), 8'(last));
      end else if (roll < 46) begin
        it = record_beat(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
      end else begin
        if (recent.size() > 0 && $urandom_range(0, 9) < 7)
          start = recent[$urandom_range(0, recent.size() - 1)];
        else
          start = 8'($urandom);
        it = lookup_beat(start, 8'($urandom));
      end
      beats.push_back(it);
    end
  endtask

  task automatic send_beat(input bbw_pkg::in_item_t it);
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  initial begin
    int idx, burst, gap, drain_at;
    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_data  <= '0;
    plan_directed();
    plan_random(RANDOM_BEATS);
    drain_at = beats.size() / 2;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    idx = 0;
    while (idx < beats.size()) begin
      burst = ($urandom_range(0, 9) == 0) ? 60 : $urandom_range(1, 12);
      while (burst > 0 && idx < beats.size()) begin
        send_beat(beats[idx]);
        idx++;
        burst--;
        if (idx == drain_at) wait_drained();
      end
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    wait_drained();
    repeat (bbw_pkg::NUM_BUSES_DEF + 8) @(posedge clk);
    $display("Covered %0d range records and %0d lookups;", records, lookups);
    $display("  %0d walks reached a top bridge, %0d hit the walk limit.", found, limited);
    if (mismatches == 0 && outstanding == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Receiver: random ready patterns plus two long hold-offs that back up the block.
  initial begin
    int       cyc, hold, mode_left;
    rx_mode_t mode;
    cyc       = 0;
    hold      = 0;
    mode_left = 0;
    mode      = RX_OPEN;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      cyc++;
      if (cyc == 3000 || cyc == 20000) hold = 600;
      if (hold > 0) begin
        hold--;
        out_ready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode      = rx_mode_t'($urandom_range(0, 2));
          mode_left = $urandom_range(10, 200);
        end
        mode_left--;
        case (mode)
          RX_OPEN: out_ready <= 1'b1;
          RX_BUSY: out_ready <= ($urandom_range(0, 3) != 0);
          default: out_ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  initial begin
    #20_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
